// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, suspended while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked at every rising edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/lzw_pkg.sv
// ----------------------------------------------------------------------------
// LZW stream encoder package
// Shared code width, transaction payload types and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package lzw_pkg;

  // Width of an emitted code; the dictionary holds 2^CODE_BITS codes.
  localparam int CODE_BITS = 12;
  // The hash table has twice as many slots as the dictionary has codes.
  localparam int HASH_BITS = CODE_BITS + 1;

  // Payload of one input transaction.
  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_stream;
  } sym_t;

  // Payload of one output transaction.
  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic                 final_code;
  } code_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SLOT,
    ST_CODE,
    ST_CHECK,
    ST_EMIT,
    ST_FINAL
  } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/lzw_stream_encoder_core.sv
// ----------------------------------------------------------------------------
// LZW stream encoder core
// Encodes a symbol stream into LZW codes using a hashed dictionary in RAM.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  sym       in         sym_valid / sym_stall     sym_data  (symbol, end_of_stream)
//  code      out        code_valid / code_stall   code_data (code, final_code)
//  apb       in/out     psel, penable, pwrite     alphabet_low, alphabet_high
//
//  An item with no prefix held becomes the prefix. Otherwise the accepting cycle is
//  followed by hash probes, each a slot read, a back-pointer read and a compare;
//  a hit extends the prefix and a miss emits the prefix code, and the last item of
//  a stream adds the final code. A collision moves on to the next slot for another
//  probe. A code held up by code_stall keeps the controller waiting in the emit or
//  final state.
//  No clearing pass: the RAMs power up zeroed, and a slot counts only if its code
//  lies below the fill count and that code points back at the slot, so reset and
//  end of stream are free.
//  The output register lets a new item enter while a code waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lzw_stream_encoder_core #(
  parameter int SYMBOL_BITS = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  // Symbol input channel
  input  wire logic          sym_valid,
  output logic               sym_stall,
  input  wire lzw_pkg::sym_t sym_data,
  // Code output channel
  output logic               code_valid,
  input  wire logic          code_stall,
  output lzw_pkg::code_t     code_data,
  // Configuration port
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready
);

  import lzw_pkg::*;

  localparam int CW    = CODE_BITS;
  localparam int SB    = SYMBOL_BITS;
  localparam int SZW   = SB + 1;
  localparam int HB    = HASH_BITS;
  localparam int ENT_W = 2 * CW + SB;

  // Initial probe slot for a (prefix, symbol code) pair.
  function automatic logic [HB-1:0] probe_hash(input logic [CW-1:0] p,
                                               input logic [SB-1:0] c);
    return {1'b0, p} ^ (HB'(c) << (HB - SB));
  endfunction

  // Registers
  logic [7:0]    alphabet_low;
  logic [7:0]    alphabet_high;
  state_t        state;
  state_t        state_next;
  logic [CW-1:0] prefix_code;
  logic          prefix_valid;
  logic [CW-1:0] dict_count;
  logic [SB-1:0] sym_code;
  logic          eos;
  logic [HB-1:0] probe;

  // Alphabet and clamping
  logic [7:0]    hi_ord;
  logic [8:0]    hi_lim;
  logic [7:0]    eff_high;
  logic [SZW-1:0] alpha_size;
  logic [7:0]    sym_lo;
  logic [7:0]    sym_clamp;
  logic [SB-1:0] sym_in_code;
  logic [CW:0]   next_free;
  logic          dict_room;

  // Memory ports
  logic [ENT_W-1:0] slot_rdata;
  logic [HB-1:0]    back_rdata;
  logic [CW-1:0]    slot_code;
  logic [CW-1:0]    slot_prefix;
  logic [SB-1:0]    slot_sym;
  logic             slot_live;
  logic             slot_hit;
  logic             dict_we;

  // Handshake controls
  logic accept;
  logic out_free;
  logic out_load;
  logic cfg_write;

  // Effective alphabet: reversed bounds collapse, width limited to 2^SB values.
  always_comb begin
    hi_ord     = (alphabet_high < alphabet_low) ? alphabet_low : alphabet_high;
    hi_lim     = {1'b0, alphabet_low} + 9'(2 ** SB - 1);
    eff_high   = ({1'b0, hi_ord} > hi_lim) ? hi_lim[7:0] : hi_ord;
    alpha_size = SZW'(eff_high - alphabet_low) + SZW'(1);
    sym_lo     = (sym_data.symbol < alphabet_low) ? alphabet_low : sym_data.symbol;
    sym_clamp  = (sym_lo > eff_high) ? eff_high : sym_lo;
    sym_in_code = SB'(sym_clamp - alphabet_low);
    next_free  = (CW + 1)'(alpha_size) + {1'b0, dict_count};
    dict_room  = !next_free[CW];
  end

  // Slot decode; a slot is live only if its code is in use and points back to it.
  always_comb begin
    slot_code   = slot_rdata[ENT_W-1 -: CW];
    slot_prefix = slot_rdata[SB +: CW];
    slot_sym    = slot_rdata[SB-1:0];
    slot_live   = ({1'b0, slot_code} >= (CW + 1)'(alpha_size)) &&
                  ({1'b0, slot_code} < next_free) && (back_rdata == probe);
    slot_hit    = slot_live && (slot_prefix == prefix_code) && (slot_sym == sym_code);
    dict_we     = (state == ST_CHECK) && !slot_live && dict_room;
  end

  // Hash table: slot -> {code, prefix, symbol code}.
  lzw_ram #(
    .WIDTH (ENT_W),
    .DEPTH (2 ** HB)
  ) u_slot_ram (
    .clk   (clk),
    .we    (dict_we),
    .waddr (probe),
    .wdata ({next_free[CW-1:0], prefix_code, sym_code}),
    .raddr (probe),
    .rdata (slot_rdata)
  );

  // Back-pointer table: code -> slot that holds it.
  lzw_ram #(
    .WIDTH (HB),
    .DEPTH (2 ** CW)
  ) u_back_ram (
    .clk   (clk),
    .we    (dict_we),
    .waddr (next_free[CW-1:0]),
    .wdata (probe),
    .raddr (slot_code),
    .rdata (back_rdata)
  );

  // Handshake and configuration port.
  assign sym_stall = (state != ST_IDLE);
  assign accept    = sym_valid && !sym_stall;
  assign out_free  = !code_valid || !code_stall;
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;
  assign prdata    = paddr[2] ? {24'd0, alphabet_high} : {24'd0, alphabet_low};

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and output load.
  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!prefix_valid) begin
            state_next = sym_data.end_of_stream ? ST_FINAL : ST_IDLE;
          end else begin
            state_next = ST_SLOT;
          end
        end
      end
      ST_SLOT: begin
        state_next = ST_CODE;
      end
      ST_CODE: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (slot_hit) begin
          state_next = eos ? ST_FINAL : ST_IDLE;
        end else if (slot_live) begin
          state_next = ST_SLOT;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = eos ? ST_FINAL : ST_IDLE;
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers: alphabet, prefix flag, fill count, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_low  <= 8'd0;
      alphabet_high <= 8'd255;
      prefix_valid  <= 1'b0;
      dict_count    <= '0;
      code_valid    <= 1'b0;
    end else begin
      if (out_load) begin
        code_valid <= 1'b1;
      end else if (!code_stall) begin
        code_valid <= 1'b0;
      end
      if (cfg_write) begin
        // A register write drops the stream in progress.
        if (paddr[2]) begin
          alphabet_high <= pwdata[7:0];
        end else begin
          alphabet_low <= pwdata[7:0];
        end
        prefix_valid <= 1'b0;
        dict_count   <= '0;
      end else if (accept && !prefix_valid) begin
        prefix_valid <= 1'b1;
      end else if (dict_we) begin
        dict_count <= dict_count + CW'(1);
      end else if ((state == ST_FINAL) && out_free) begin
        prefix_valid <= 1'b0;
        dict_count   <= '0;
      end
    end
  end

  // Datapath registers: prefix, latched item, probe slot, output payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      sym_code <= sym_in_code;
      eos      <= sym_data.end_of_stream;
      if (!prefix_valid) begin
        prefix_code <= CW'(sym_in_code);
      end else begin
        probe <= probe_hash(prefix_code, sym_in_code);
      end
    end
    if (state == ST_CHECK) begin
      if (slot_hit) begin
        prefix_code <= slot_code;
      end else if (slot_live) begin
        probe <= probe + HB'(1);
      end
    end
    if (out_load) begin
      code_data.code       <= prefix_code;
      code_data.final_code <= (state == ST_FINAL);
      if (state == ST_EMIT) begin
        prefix_code <= CW'(sym_code);
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/lzw_ram.sv
// ----------------------------------------------------------------------------
// LZW generic RAM
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lzw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  // Contents power up as zero, so an entry never written reads as a known value.
  logic [WIDTH-1:0] mem [DEPTH] = '{default: '0};

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/lzw_checker.sv
// ----------------------------------------------------------------------------
// LZW encoder port checker
// Watches the top-level channels and flags protocol and reset slips.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lzw_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           sym_valid,
  input wire logic           sym_stall,
  input wire lzw_pkg::sym_t  sym_data,
  input wire logic           code_valid,
  input wire logic           code_stall,
  input wire lzw_pkg::code_t code_data
);

  // A stalled symbol transaction stays offered with the same payload.
  `ASSERT_CLK(a_in_hold, sym_valid && sym_stall |=> sym_valid && $stable(sym_data), "sym_data moved")

  // A stalled result transaction stays offered.
  `ASSERT_CLK(a_out_hold_valid, code_valid && code_stall |=> code_valid, "code_valid dropped")

  // A stalled result payload does not change.
  `ASSERT_CLK(a_out_hold_data, code_valid && code_stall |=> $stable(code_data), "code_data moved")

  // Reset leaves no result pending.
  `ASSERT_CLK_ALWAYS(a_rst_out, rst |=> !code_valid, "code_valid after reset")

  // Reset leaves the encoder ready for a new symbol.
  `ASSERT_CLK_ALWAYS(a_rst_in, rst |=> !sym_stall, "sym_stall after reset")

endmodule

bind lzw_stream_encoder_core lzw_checker u_lzw_checker (
  .clk        (clk),
  .rst        (rst),
  .sym_valid  (sym_valid),
  .sym_stall  (sym_stall),
  .sym_data   (sym_data),
  .code_valid (code_valid),
  .code_stall (code_stall),
  .code_data  (code_data)
);

`default_nettype wire
